>>> sv/pru_pkg.sv
// Shared types and constants for the pixel replicate upscaler.
// Used by the channel interfaces and every module of the block.
`timescale 1ns / 1ps
package pru_pkg;

   // Fixed field widths
   localparam int PIXEL_W = 32;
   localparam int INDEX_W = 26;
   localparam int SIZE_W  = 11;
   localparam int SCALE_W = 4;
   localparam int CSR_IDX_W = 2;

   // Largest frame side is 2047 (SIZE_W bits), so a column or row fits in 11 bits
   localparam int BASE_W = 16;  // column * scale or row * scale
   localparam int DWID_W = 15;  // width * x scale

   // Register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_XSCALE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YSCALE = 2'd3;

   // Job queue between front and back (depth is a power of two)
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // One classified pixel waiting to be replicated
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [BASE_W-1:0]  base_x;
      logic [BASE_W-1:0]  base_y;
      logic [DWID_W-1:0]  dest_w;
      logic [SCALE_W-1:0] xs;
      logic [SCALE_W-1:0] ys;
      logic               frame_end;
   } job_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

>>> sv/pru_if.sv
// Valid/ready channel interfaces of the pixel replicate upscaler.
// Depends on pru_pkg for field widths.
`timescale 1ns / 1ps

// Source pixel channel
interface pru_pixel_if;
   logic                        valid;
   logic                        ready;
   logic [pru_pkg::PIXEL_W-1:0] pixel_word;
   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

// Destination write channel
interface pru_write_if;
   logic                        valid;
   logic                        ready;
   logic [pru_pkg::INDEX_W-1:0] dest_index;
   logic [pru_pkg::PIXEL_W-1:0] dest_pixel;
   logic                        last_write;
   logic                        frame_done;
   modport source (output valid, output dest_index, output dest_pixel,
                   output last_write, output frame_done, input ready);
   modport sink   (input valid, input dest_index, input dest_pixel,
                   input last_write, input frame_done, output ready);
endinterface

// Register write channel
interface pru_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pru_pkg::CSR_IDX_W-1:0] index;
   logic [pru_pkg::SIZE_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/pru_front.sv
// Front of the upscaler: registers, source counters and job classification.
// Depends on pru_pkg and the channel interfaces in pru_if.
`timescale 1ns / 1ps
module pru_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_SCALE  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   pru_pixel_if.sink            req_chan,
   pru_csr_if.sink              csr_chan,
   input  pru_pkg::q_stat_type  q_stat,
   output logic                 push,
   output pru_pkg::job_type     push_job
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [pru_pkg::SIZE_W-1:0]  width_ff, width_in;
   logic [pru_pkg::SIZE_W-1:0]  height_ff, height_in;
   logic [pru_pkg::SCALE_W-1:0] xscale_ff, xscale_in;
   logic [pru_pkg::SCALE_W-1:0] yscale_ff, yscale_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;

   logic [pru_pkg::SIZE_W-1:0]  w_eff, h_eff;
   logic [pru_pkg::SCALE_W-1:0] xs_eff, ys_eff;
   logic [12:0]                 col_nx, row_nx;
   logic                        row_end, frame_end, accept;

   // Register writes
   assign csr_chan.ready = 1'b1;
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      xscale_in = xscale_ff;
      yscale_in = yscale_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            pru_pkg::CSR_WIDTH:  width_in  = csr_chan.data;
            pru_pkg::CSR_HEIGHT: height_in = csr_chan.data;
            pru_pkg::CSR_XSCALE: xscale_in = csr_chan.data[pru_pkg::SCALE_W-1:0];
            pru_pkg::CSR_YSCALE: yscale_in = csr_chan.data[pru_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp sizes to 1..max and scales to 0..max
   always_comb begin
      if (width_ff == '0)                  w_eff = pru_pkg::SIZE_W'(1);
      else if (int'(width_ff) > MAX_WIDTH) w_eff = pru_pkg::SIZE_W'(MAX_WIDTH);
      else                                 w_eff = width_ff;
      if (height_ff == '0)                   h_eff = pru_pkg::SIZE_W'(1);
      else if (int'(height_ff) > MAX_HEIGHT) h_eff = pru_pkg::SIZE_W'(MAX_HEIGHT);
      else                                   h_eff = height_ff;
      xs_eff = (int'(xscale_ff) > MAX_SCALE) ? pru_pkg::SCALE_W'(MAX_SCALE) : xscale_ff;
      ys_eff = (int'(yscale_ff) > MAX_SCALE) ? pru_pkg::SCALE_W'(MAX_SCALE) : yscale_ff;
   end

   // Column and row wrap
   assign col_nx    = 13'(col_ff) + 13'd1;
   assign row_nx    = 13'(row_ff) + 13'd1;
   assign row_end   = col_nx >= 13'(w_eff);
   assign frame_end = row_end && (row_nx >= 13'(h_eff));

   assign req_chan.ready = !q_stat.full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_nx[ROW_W-1:0];
         end else begin
            col_in = col_nx[COL_W-1:0];
         end
      end
   end

   // Classify: a zero scale consumes the pixel but queues no job
   assign push = accept && (xs_eff != '0) && (ys_eff != '0);
   always_comb begin
      push_job.pixel     = req_chan.pixel_word;
      push_job.base_x    = pru_pkg::BASE_W'(col_ff) * pru_pkg::BASE_W'(xs_eff);
      push_job.base_y    = pru_pkg::BASE_W'(row_ff) * pru_pkg::BASE_W'(ys_eff);
      push_job.dest_w    = pru_pkg::DWID_W'(w_eff) * pru_pkg::DWID_W'(xs_eff);
      push_job.xs        = xs_eff;
      push_job.ys        = ys_eff;
      push_job.frame_end = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pru_pkg::SIZE_W'(1);
         height_ff <= pru_pkg::SIZE_W'(1);
         xscale_ff <= pru_pkg::SCALE_W'(1);
         yscale_ff <= pru_pkg::SCALE_W'(1);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         xscale_ff <= xscale_in;
         yscale_ff <= yscale_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

>>> sv/pru_queue.sv
// Short job queue between the front and the back of the upscaler.
// Depends on pru_pkg for the job type and depth constants.
`timescale 1ns / 1ps
module pru_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pru_pkg::job_type    push_job,
   input  logic                pop,
   output pru_pkg::job_type    head,
   output pru_pkg::q_stat_type stat
);

   pru_pkg::job_type             slot_ff [pru_pkg::Q_DEPTH];
   logic [pru_pkg::Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pru_pkg::Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pru_pkg::Q_CNT_W-1:0]  count_ff, count_in;

   assign stat.full  = count_ff == pru_pkg::Q_CNT_W'(pru_pkg::Q_DEPTH);
   assign stat.empty = count_ff == '0;
   assign head       = slot_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> sv/pru_back.sv
// Back of the upscaler: walks the replica block of one job, one write a cycle unless the write channel stalls.
// Depends on pru_pkg and the write channel interface in pru_if.
`timescale 1ns / 1ps
module pru_back (
   input  logic                clock,
   input  logic                reset,
   input  pru_pkg::job_type    head,
   input  pru_pkg::q_stat_type q_stat,
   output logic                pop,
   pru_write_if.source         rsp_chan
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0]                  state_ff, state_in;
   pru_pkg::job_type            job_ff, job_in;
   logic [pru_pkg::INDEX_W-1:0] line_ff, line_in;
   logic [pru_pkg::SCALE_W-1:0] dx_ff, dx_in, dy_ff, dy_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pru_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [pru_pkg::PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_done_ff, rsp_done_in;

   logic [pru_pkg::BASE_W+pru_pkg::DWID_W-1:0] row_prod;
   logic slot_free, x_end, y_end, emit;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop       = (state_ff == ST_IDLE) && !q_stat.empty;
   assign emit      = (state_ff == ST_RUN) && slot_free;
   assign x_end     = dx_ff == job_ff.xs - 1'b1;
   assign y_end     = dy_ff == job_ff.ys - 1'b1;

   // Start of the first replica row, taken modulo the index width
   assign row_prod = job_ff.base_y * job_ff.dest_w;

   // Sequencer over the replica rows and columns
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      line_in  = line_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               job_in   = head;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            line_in  = row_prod[pru_pkg::INDEX_W-1:0]
                       + pru_pkg::INDEX_W'(job_ff.base_x);
            dx_in    = '0;
            dy_in    = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (emit) begin
               if (x_end) begin
                  dx_in   = '0;
                  dy_in   = dy_ff + 1'b1;
                  line_in = line_ff + pru_pkg::INDEX_W'(job_ff.dest_w);
                  if (y_end) state_in = ST_IDLE;
               end else begin
                  dx_in = dx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (slot_free) begin
         rsp_valid_in = emit;
         rsp_index_in = line_ff + pru_pkg::INDEX_W'(dx_ff);
         rsp_pixel_in = job_ff.pixel;
         rsp_last_in  = x_end && y_end;
         rsp_done_in  = x_end && y_end && job_ff.frame_end;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.dest_index = rsp_index_ff;
   assign rsp_chan.dest_pixel = rsp_pixel_ff;
   assign rsp_chan.last_write = rsp_last_ff;
   assign rsp_chan.frame_done = rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      line_ff      <= line_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      rsp_index_ff <= rsp_index_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

endmodule

>>> sv/pixel_replicate_upscale_unit.sv
// Pixel replicate upscaler: x_scale by y_scale writes per source pixel.
// A pixel passes the job queue, then the back's multiply and run states, with one
// write per cycle unless the write channel stalls; the back pops only when idle.
// A zero scale pixel is consumed at the front and yields nothing.
// Reset (synchronous, high) sets sizes and scales to 1, counters and queue to 0.
`timescale 1ns / 1ps
module pixel_replicate_upscale_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_SCALE  = 8
) (
   input  logic        clock,
   input  logic        reset,
   pru_pixel_if.sink   req_chan,
   pru_write_if.source rsp_chan,
   pru_csr_if.sink     csr_chan
);

   pru_pkg::q_stat_type q_stat;
   pru_pkg::job_type    push_job, head;
   logic                push, pop;

   pru_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_SCALE  (MAX_SCALE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_job (push_job)
   );

   pru_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .stat     (q_stat)
   );

   pru_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   // The queue is never written when full unless also read, nor read when empty
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full || pop)
      else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("job queue underflow");
   // End of frame only on the last write of a pixel
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_done |-> rsp_chan.last_write)
      else $error("frame_done without last_write");
`endif

endmodule
